/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the tilt sensor fusion block.
// Standalone header; the including module must have clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define TSF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Clocked check that also runs through reset.
`define TSF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) \
      else $error(msg);

`endif

/* hw/rtl/tsf_pkg.sv */
// Types, constants and helpers for the tilt sensor fusion block.
// No dependencies; used by every RTL module of the block.
package tsf_pkg;

   localparam int REG_COUNT       = 8;
   localparam int LANE_COUNT      = 7;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int RAW_WIDTH   = 17;  // 16-bit sample, sign or zero extended
   localparam int CAL_WIDTH   = 32;
   localparam int SAT_WIDTH   = 50;  // widest intermediate handed to sat32
   localparam int VEC_WIDTH   = 36;  // CORDIC x/y with pre-rotation and gain growth
   localparam int ANGLE_WIDTH = 20;  // CORDIC angle accumulator
   localparam int TILT_WIDTH  = 19;
   localparam int MAX_STAGES  = 24;

   localparam int ALPHA_SHIFT = 15;
   localparam int RECIP_SHIFT = 8;

   localparam logic signed [ANGLE_WIDTH-1:0] PI_Q16      = 20'sd205887;
   localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q16 = 20'sd102944;

   localparam logic signed [SAT_WIDTH-1:0] S32_MAX = 50'sd2147483647;
   localparam logic signed [SAT_WIDTH-1:0] S32_MIN = -50'sd2147483648;

   // atan(2^-i) in Q3.16, rounded to nearest
   localparam logic [15:0] ATAN_Q16 [MAX_STAGES] = '{
      16'd51472, 16'd30385, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
      16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2,
      16'd1,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0
   };

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_CAL_ACCEL_X1 = 3'd0,
      REG_CAL_ACCEL_X2 = 3'd1,
      REG_CAL_ACCEL_Y1 = 3'd2,
      REG_CAL_ACCEL_Y2 = 3'd3,
      REG_CAL_GYRO_ONE = 3'd4,
      REG_CAL_GYRO_TWO = 3'd5,
      REG_CAL_YAW_RATE = 3'd6,
      REG_GEOMETRY     = 3'd7
   } csr_index_type;

   typedef enum logic {
      LANE_LINEAR = 1'b0,  // raw * gain + offset
      LANE_GYRO   = 1'b1   // (raw + offset) * gain
   } lane_mode_type;

   typedef struct packed {
      logic signed [15:0] accel_x1;
      logic signed [15:0] accel_x2;
      logic signed [15:0] accel_y1;
      logic signed [15:0] accel_y2;
      logic signed [15:0] gyro_one;
      logic signed [15:0] gyro_two;
      logic        [15:0] yaw_raw;
   } req_type;

   typedef struct packed {
      logic signed [TILT_WIDTH-1:0] tilt_angle;
      logic signed [31:0]           tilt_rate;
      logic signed [31:0]           tilt_accel;
      logic signed [31:0]           yaw_rate;
   } rsp_type;

   // calibrated channels, lanes to merge stage
   typedef struct packed {
      logic signed [CAL_WIDTH-1:0] x1;
      logic signed [CAL_WIDTH-1:0] x2;
      logic signed [CAL_WIDTH-1:0] y1;
      logic signed [CAL_WIDTH-1:0] y2;
      logic signed [CAL_WIDTH-1:0] g1;
      logic signed [CAL_WIDTH-1:0] g2;
      logic signed [CAL_WIDTH-1:0] yaw;
   } chan_type;

   // vector handed to the CORDIC
   typedef struct packed {
      logic signed [CAL_WIDTH-1:0] num;
      logic signed [CAL_WIDTH-1:0] den;
   } vec_type;

   // results that bypass the CORDIC
   typedef struct packed {
      logic signed [31:0] tilt_rate;
      logic signed [31:0] tilt_accel;
      logic signed [31:0] yaw_rate;
   } side_type;

   function automatic logic signed [CAL_WIDTH-1:0] sat32(input logic signed [SAT_WIDTH-1:0] v);
      logic signed [CAL_WIDTH-1:0] r;
      if (v > S32_MAX) begin
         r = S32_MAX[CAL_WIDTH-1:0];
      end else if (v < S32_MIN) begin
         r = S32_MIN[CAL_WIDTH-1:0];
      end else begin
         r = v[CAL_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/tsf_cal_lane.sv */
// One calibration lane: gain/offset correction of one sensor channel.
// Depends on tsf_pkg.
module tsf_cal_lane (
   input  logic                                  clock,
   input  tsf_pkg::lane_mode_type                lane_mode,
   input  logic signed [tsf_pkg::RAW_WIDTH-1:0]  raw,
   input  logic [tsf_pkg::CSR_DATA_WIDTH-1:0]    cal,
   output logic signed [tsf_pkg::CAL_WIDTH-1:0]  cal_value
);
   import tsf_pkg::*;

   localparam int PRE_WIDTH  = RAW_WIDTH + 1;
   localparam int PROD_WIDTH = PRE_WIDTH + 16;

   logic signed [15:0]            gain;
   logic signed [15:0]            offset;
   logic signed [PRE_WIDTH-1:0]   mult_a;
   logic signed [PROD_WIDTH-1:0]  prod;
   logic signed [PROD_WIDTH:0]    sum;
   logic signed [CAL_WIDTH-1:0]   cal_value_in;
   logic signed [CAL_WIDTH-1:0]   cal_value_ff;

   always_comb begin
      gain   = $signed(cal[31:16]);
      offset = $signed(cal[15:0]);
      unique case (lane_mode)
         LANE_GYRO: begin
            mult_a = PRE_WIDTH'(raw) + PRE_WIDTH'(offset);
            prod   = PROD_WIDTH'(mult_a) * PROD_WIDTH'(gain);
            sum    = (PROD_WIDTH+1)'(prod);
         end
         default: begin
            mult_a = PRE_WIDTH'(raw);
            prod   = PROD_WIDTH'(mult_a) * PROD_WIDTH'(gain);
            sum    = (PROD_WIDTH+1)'(prod) + (PROD_WIDTH+1)'(offset);
         end
      endcase
      cal_value_in = sat32(SAT_WIDTH'(sum));
   end

   always_ff @(posedge clock) begin
      cal_value_ff <= cal_value_in;
   end

   assign cal_value = cal_value_ff;

endmodule

/* hw/rtl/tsf_merge.sv */
// Merge stage: combines the calibrated lanes into the tilt vector,
// mean gyro rate and angular acceleration. Two stages. Depends on tsf_pkg.
module tsf_merge (
   input  logic                               clock,
   input  tsf_pkg::chan_type                  chan,
   input  logic [tsf_pkg::CSR_DATA_WIDTH-1:0] geometry,
   output tsf_pkg::vec_type                   vec,
   output tsf_pkg::side_type                  side
);
   import tsf_pkg::*;

   localparam int AP_WIDTH   = CAL_WIDTH + 16;      // alpha products
   localparam int DIFF_WIDTH = CAL_WIDTH + 1;
   localparam int ACC_WIDTH  = DIFF_WIDTH + 16;

   logic signed [15:0]            alpha;
   logic signed [15:0]            recip;

   // stage A
   logic signed [AP_WIDTH-1:0]    px2_in, px2_ff;
   logic signed [AP_WIDTH-1:0]    py2_in, py2_ff;
   logic signed [CAL_WIDTH-1:0]   x1_ff, y1_ff, yaw_ff;
   logic signed [DIFF_WIDTH-1:0]  diff_in, diff_ff;
   logic signed [DIFF_WIDTH-1:0]  gsum;
   logic signed [CAL_WIDTH-1:0]   rate_in, rate_ff;

   // stage B
   logic signed [AP_WIDTH-1:0]    px2_shr, py2_shr;
   logic signed [ACC_WIDTH-1:0]   acc_prod;
   logic signed [ACC_WIDTH-1:0]   acc_shr;
   vec_type                       vec_in, vec_ff;
   side_type                      side_in, side_ff;

   always_comb begin
      alpha   = $signed(geometry[31:16]);
      recip   = $signed(geometry[15:0]);
      px2_in  = AP_WIDTH'(chan.x2) * AP_WIDTH'(alpha);
      py2_in  = AP_WIDTH'(chan.y2) * AP_WIDTH'(alpha);
      diff_in = DIFF_WIDTH'(chan.x1) - DIFF_WIDTH'(chan.x2);
      gsum    = DIFF_WIDTH'(chan.g1) + DIFF_WIDTH'(chan.g2);
      rate_in = gsum[DIFF_WIDTH-1:1];  // floor of half
   end

   always_ff @(posedge clock) begin
      px2_ff  <= px2_in;
      py2_ff  <= py2_in;
      x1_ff   <= chan.x1;
      y1_ff   <= chan.y1;
      diff_ff <= diff_in;
      rate_ff <= rate_in;
      yaw_ff  <= chan.yaw;
   end

   always_comb begin
      px2_shr            = px2_ff >>> ALPHA_SHIFT;
      py2_shr            = py2_ff >>> ALPHA_SHIFT;
      vec_in.num         = sat32(SAT_WIDTH'(x1_ff) - SAT_WIDTH'(px2_shr));
      vec_in.den         = sat32(SAT_WIDTH'(y1_ff) - SAT_WIDTH'(py2_shr));
      acc_prod           = ACC_WIDTH'(diff_ff) * ACC_WIDTH'(recip);
      acc_shr            = acc_prod >>> RECIP_SHIFT;
      side_in.tilt_rate  = rate_ff;
      side_in.tilt_accel = sat32(SAT_WIDTH'(acc_shr));
      side_in.yaw_rate   = yaw_ff;
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      side_ff <= side_in;
   end

   assign vec  = vec_ff;
   assign side = side_ff;

endmodule

/* hw/rtl/tsf_cordic.sv */
// Pipelined vectoring CORDIC: angle = -atan2(num, den), accumulated in Q3.16 and output in Q2.16.
// One pre-rotation stage, STAGES micro-rotations, one output stage. Depends on tsf_pkg.
module tsf_cordic #(
   parameter int STAGES = 16
) (
   input  logic                                   clock,
   input  tsf_pkg::vec_type                       vec,
   output logic signed [tsf_pkg::TILT_WIDTH-1:0]  angle
);
   import tsf_pkg::*;

   logic signed [VEC_WIDTH-1:0]   x_in [STAGES+1];
   logic signed [VEC_WIDTH-1:0]   x_ff [STAGES+1];
   logic signed [VEC_WIDTH-1:0]   y_in [STAGES+1];
   logic signed [VEC_WIDTH-1:0]   y_ff [STAGES+1];
   logic signed [ANGLE_WIDTH-1:0] z_in [STAGES+1];
   logic signed [ANGLE_WIDTH-1:0] z_ff [STAGES+1];
   logic                          zero_in [STAGES+1];
   logic                          zero_ff [STAGES+1];

   logic signed [VEC_WIDTH-1:0]   x0, y0, xs, ys;
   logic signed [ANGLE_WIDTH-1:0] step;
   logic signed [ANGLE_WIDTH-1:0] zc, zn;
   logic signed [TILT_WIDTH-1:0]  angle_in, angle_ff;

   always_comb begin
      // quarter-turn pre-rotation brings den into the right half plane
      y0         = VEC_WIDTH'(vec.num);
      x0         = VEC_WIDTH'(vec.den);
      zero_in[0] = (vec.num == '0) && (vec.den == '0);
      if (x0 < 0) begin
         if (y0 >= 0) begin
            x_in[0] = y0;
            y_in[0] = -x0;
            z_in[0] = HALF_PI_Q16;
         end else begin
            x_in[0] = -y0;
            y_in[0] = x0;
            z_in[0] = -HALF_PI_Q16;
         end
      end else begin
         x_in[0] = x0;
         y_in[0] = y0;
         z_in[0] = '0;
      end

      for (int i = 0; i < STAGES; i++) begin
         xs   = x_ff[i] >>> i;
         ys   = y_ff[i] >>> i;
         step = $signed(ANGLE_WIDTH'(ATAN_Q16[i]));
         if (y_ff[i] < 0) begin
            x_in[i+1] = x_ff[i] - ys;
            y_in[i+1] = y_ff[i] + xs;
            z_in[i+1] = z_ff[i] - step;
         end else begin
            x_in[i+1] = x_ff[i] + ys;
            y_in[i+1] = y_ff[i] - xs;
            z_in[i+1] = z_ff[i] + step;
         end
         zero_in[i+1] = zero_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   // clamp to +/-pi, negate; zero vector gives zero
   always_comb begin
      zc = z_ff[STAGES];
      if (zc > PI_Q16) begin
         zc = PI_Q16;
      end else if (zc < -PI_Q16) begin
         zc = -PI_Q16;
      end
      zn       = -zc;
      angle_in = zero_ff[STAGES] ? '0 : zn[TILT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

/* hw/rtl/tilt_sensor_fusion_top.sv */
// Tilt sensor fusion, top level. Depends on tsf_pkg, tsf_cal_lane, tsf_merge,
// tsf_cordic and assert_macros.svh.
//
// Usage:
//  - Input: a sample set on req_data is taken at a clock edge with start high
//    and busy low. busy is low except while reset is high.
//  - Output: each result is on rsp_data for exactly one cycle with rsp_valid
//    high; there is no backpressure, the receiver takes every transfer.
//  - Calibration: eight 32-bit registers written through csr_we, csr_index
//    and csr_wdata, one write per cycle, no read-back. Write only while no
//    sample is in flight.
//  - Throughput: one sample set per cycle, back to back, while busy is low.
//  - Pipeline: one calibration stage across seven parallel lanes, two merge
//    stages, and the pre-rotation, micro-rotation and output stages of the
//    CORDIC chain, which sets the depth.
//  - Reset (synchronous): clears the calibration registers and drops every
//    sample in flight; nothing comes out for a flushed sample.
//
`include "assert_macros.svh"

module tilt_sensor_fusion_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  tsf_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   output tsf_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  tsf_pkg::csr_index_type             csr_index,
   input  logic [tsf_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import tsf_pkg::*;

   localparam int CORDIC_LAT = CORDIC_STAGES + 2;
   localparam int MERGE_TAP  = 2;                 // valid tap aligned with merge output
   localparam int LATENCY    = MERGE_TAP + 1 + CORDIC_LAT;

   logic                          accept;
   logic [CSR_DATA_WIDTH-1:0]     cfg_ff [REG_COUNT];
   logic [LATENCY-1:0]            valid_in, valid_ff;

   logic signed [RAW_WIDTH-1:0]   lane_raw [LANE_COUNT];
   logic signed [CAL_WIDTH-1:0]   lane_cal [LANE_COUNT];
   chan_type                      chan;
   vec_type                       vec;
   side_type                      side;
   side_type                      side_ff [CORDIC_LAT];
   logic signed [TILT_WIDTH-1:0]  angle;

   logic                          angle_in_range;
   logic                          zero_vec_in;

   // handshake: no internal stall, only reset holds off a transfer
   assign busy   = reset;
   assign accept = start & ~busy;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // lane inputs; yaw is unsigned, the rest sign extend
   always_comb begin
      lane_raw[REG_CAL_ACCEL_X1] = RAW_WIDTH'(req_data.accel_x1);
      lane_raw[REG_CAL_ACCEL_X2] = RAW_WIDTH'(req_data.accel_x2);
      lane_raw[REG_CAL_ACCEL_Y1] = RAW_WIDTH'(req_data.accel_y1);
      lane_raw[REG_CAL_ACCEL_Y2] = RAW_WIDTH'(req_data.accel_y2);
      lane_raw[REG_CAL_GYRO_ONE] = RAW_WIDTH'(req_data.gyro_one);
      lane_raw[REG_CAL_GYRO_TWO] = RAW_WIDTH'(req_data.gyro_two);
      lane_raw[REG_CAL_YAW_RATE] = {1'b0, req_data.yaw_raw};
   end

   // seven calibration lanes; lane k uses calibration register k
   for (genvar k = 0; k < LANE_COUNT; k++) begin : g_lane
      tsf_cal_lane u_lane (
         .clock     (clock),
         .lane_mode ((k == REG_CAL_GYRO_ONE || k == REG_CAL_GYRO_TWO) ?
                     LANE_GYRO : LANE_LINEAR),
         .raw       (lane_raw[k]),
         .cal       (cfg_ff[k]),
         .cal_value (lane_cal[k])
      );
   end

   always_comb begin
      chan.x1  = lane_cal[REG_CAL_ACCEL_X1];
      chan.x2  = lane_cal[REG_CAL_ACCEL_X2];
      chan.y1  = lane_cal[REG_CAL_ACCEL_Y1];
      chan.y2  = lane_cal[REG_CAL_ACCEL_Y2];
      chan.g1  = lane_cal[REG_CAL_GYRO_ONE];
      chan.g2  = lane_cal[REG_CAL_GYRO_TWO];
      chan.yaw = lane_cal[REG_CAL_YAW_RATE];
   end

   tsf_merge u_merge (
      .clock    (clock),
      .chan     (chan),
      .geometry (cfg_ff[REG_GEOMETRY]),
      .vec      (vec),
      .side     (side)
   );

   tsf_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock (clock),
      .vec   (vec),
      .angle (angle)
   );

   // rate, accel and yaw wait alongside the CORDIC
   always_ff @(posedge clock) begin
      side_ff[0] <= side;
      for (int i = 1; i < CORDIC_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // valid tracks each transfer through the pipeline
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LATENCY-1];

   always_comb begin
      rsp_data.tilt_angle = angle;
      rsp_data.tilt_rate  = side_ff[CORDIC_LAT-1].tilt_rate;
      rsp_data.tilt_accel = side_ff[CORDIC_LAT-1].tilt_accel;
      rsp_data.yaw_rate   = side_ff[CORDIC_LAT-1].yaw_rate;
   end

   // assertion helpers
   assign angle_in_range = (rsp_data.tilt_angle <= PI_Q16) && (rsp_data.tilt_angle >= -PI_Q16);
   assign zero_vec_in    = valid_ff[MERGE_TAP] && (vec.num == '0) && (vec.den == '0);

   // every accepted sample comes out with rsp_valid high
   `TSF_ASSERT(a_latency, accept |-> ##LATENCY rsp_valid, "result missing after latency")
   // angle stays inside +/-pi
   `TSF_ASSERT(a_angle_range, rsp_valid |-> angle_in_range, "tilt angle out of range")
   // zero vector into the CORDIC gives a zero angle
   `TSF_ASSERT(a_zero_vec, zero_vec_in |-> ##CORDIC_LAT (angle == '0), "zero vector, nonzero angle")
   // reset flushes the pipeline
   `TSF_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_valid, "result after reset")

endmodule
